[sv/hcrc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcrc_pkg
// Shared types and constants for the heat/cool relay controller.
// ----------------------------------------------------------------------------
package hcrc_pkg;

  localparam int TIME_BITS = 32;
  localparam int TEMP_BITS = 14;
  localparam int CFG_BITS  = 16;
  localparam int IDX_BITS  = 3;
  // working width for temperature sums and differences
  localparam int TW        = TEMP_BITS + 3;

  typedef logic        [TIME_BITS-1:0] time_t;
  typedef logic signed [TEMP_BITS-1:0] temp_t;
  typedef logic signed [TW-1:0]        temp_w_t;
  typedef logic        [CFG_BITS-1:0]  secs_t;
  typedef logic        [IDX_BITS-1:0]  cfg_idx_t;

  typedef enum logic [1:0] {
    MODE_OFF     = 2'd0,
    MODE_ON      = 2'd1,
    MODE_PENDING = 2'd2
  } mode_t;

  // register indexes
  localparam cfg_idx_t REG_HEAT_MIN_OFF = 3'd0;
  localparam cfg_idx_t REG_COOL_TO_HEAT = 3'd1;
  localparam cfg_idx_t REG_COOL_MIN_OFF = 3'd2;
  localparam cfg_idx_t REG_HEAT_TO_COOL = 3'd3;
  localparam cfg_idx_t REG_COOL_MIN_ON  = 3'd4;

  // register reset values
  localparam secs_t HEAT_MIN_OFF_RST = 16'd300;
  localparam secs_t COOL_TO_HEAT_RST = 16'd300;
  localparam secs_t COOL_MIN_OFF_RST = 16'd300;
  localparam secs_t HEAT_TO_COOL_RST = 16'd300;
  localparam secs_t COOL_MIN_ON_RST  = 16'd120;

  // temperature constants, 1/16 degree
  localparam temp_w_t WARM_FAR_DIFF  = TW'(80);   // 5.0
  localparam temp_w_t WARM_NEAR_DIFF = TW'(32);   // 2.0
  localparam temp_w_t WARM_FAR_LIM   = TW'(160);  // 10
  localparam temp_w_t WARM_NEAR_LIM  = TW'(80);   // 5
  localparam temp_w_t COOL_DIFF      = -TW'(80);  // -5.0
  localparam temp_w_t COOL_LIM       = TW'(320);  // 20
  localparam temp_w_t BAND_HI        = TW'(8);    // 0.5
  localparam temp_w_t BAND_LO        = -TW'(8);   // -0.5

  typedef struct packed {
    time_t now_seconds;
    temp_t setpoint_temp;
    temp_t beer_temp;
    temp_t chamber_temp;
    temp_t loop_target;
  } item_t;

endpackage

[sv/hcrc_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcrc_if
// Channel interfaces: configuration writes, input samples, relay results.
// ----------------------------------------------------------------------------
interface hcrc_cfg_if import hcrc_pkg::*; ();
  logic     valid;
  logic     ready;
  cfg_idx_t index;
  secs_t    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

interface hcrc_in_if import hcrc_pkg::*; ();
  logic  valid;
  logic  ready;
  time_t now_seconds;
  temp_t setpoint_temp;
  temp_t beer_temp;
  temp_t chamber_temp;
  temp_t loop_target;

  modport source (output valid, now_seconds, setpoint_temp, beer_temp, chamber_temp,
                  loop_target, input ready);
  modport sink   (input valid, now_seconds, setpoint_temp, beer_temp, chamber_temp,
                  loop_target, output ready);
endinterface

interface hcrc_out_if import hcrc_pkg::*; ();
  logic        valid;
  logic        ready;
  logic        heat_relay;
  logic        cool_relay;
  logic [1:0]  heat_mode;
  logic [1:0]  cool_mode;

  modport source (output valid, heat_relay, cool_relay, heat_mode, cool_mode, input ready);
  modport sink   (input valid, heat_relay, cool_relay, heat_mode, cool_mode, output ready);
endinterface

[sv/heat_cool_relay_controller.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heat_cool_relay_controller
// Thermostat with short-cycle protection for heat and cool relays.
// ----------------------------------------------------------------------------
// An input transaction passes through the input register, then the result register.
// One item per cycle unless result stalls; the result register parts the two channels.
// Relay state and off/on stamps update as an item moves into the result register.
// Reset (rst, synchronous): relays off, stamps zero, timing registers at defaults.
module heat_cool_relay_controller import hcrc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  hcrc_cfg_if.sink   cfg,
  hcrc_in_if.sink    item,
  hcrc_out_if.source result
);

  secs_t heat_min_off;
  secs_t cool_to_heat;
  secs_t cool_min_off;
  secs_t heat_to_cool;
  secs_t cool_min_on;

  mode_t heat_state, heat_state_next;
  mode_t cool_state, cool_state_next;
  time_t heat_off_stamp, heat_off_stamp_next;
  time_t cool_on_stamp, cool_on_stamp_next;
  time_t cool_off_stamp, cool_off_stamp_next;

  logic  s1_valid;
  item_t s1;
  logic  out_valid;
  logic  advance;

  assign cfg.ready   = 1'b1;
  assign advance     = s1_valid && (!out_valid || result.ready);
  assign item.ready  = !s1_valid || advance;
  assign result.valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      heat_min_off <= HEAT_MIN_OFF_RST;
      cool_to_heat <= COOL_TO_HEAT_RST;
      cool_min_off <= COOL_MIN_OFF_RST;
      heat_to_cool <= HEAT_TO_COOL_RST;
      cool_min_on  <= COOL_MIN_ON_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_HEAT_MIN_OFF: heat_min_off <= cfg.data;
        REG_COOL_TO_HEAT: cool_to_heat <= cfg.data;
        REG_COOL_MIN_OFF: cool_min_off <= cfg.data;
        REG_HEAT_TO_COOL: heat_to_cool <= cfg.data;
        REG_COOL_MIN_ON:  cool_min_on  <= cfg.data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item.ready) begin
      s1_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      s1.now_seconds   <= item.now_seconds;
      s1.setpoint_temp <= item.setpoint_temp;
      s1.beer_temp     <= item.beer_temp;
      s1.chamber_temp  <= item.chamber_temp;
      s1.loop_target   <= item.loop_target;
    end
  end

  // target clamp and deadband
  temp_w_t setp, beer, chamber, target_in, diff, target_a, target_c, err;
  logic    want_cool, want_heat;

  always_comb begin
    setp      = TW'(s1.setpoint_temp);
    beer      = TW'(s1.beer_temp);
    chamber   = TW'(s1.chamber_temp);
    target_in = TW'(s1.loop_target);
    diff      = setp - beer;
    target_a  = target_in;
    target_c  = target_in;
    if (setp > beer) begin
      if (diff < WARM_FAR_DIFF && target_in > beer + WARM_FAR_LIM) begin
        target_a = beer + WARM_FAR_LIM;
      end
      target_c = target_a;
      if (diff < WARM_NEAR_DIFF && target_a > beer + WARM_NEAR_LIM) begin
        target_c = beer + WARM_NEAR_LIM;
      end
    end else begin
      if (diff < COOL_DIFF && target_in < beer - COOL_LIM) begin
        target_c = beer - COOL_LIM;
      end
    end
    err       = chamber - target_c;
    want_cool = err > BAND_HI;
    want_heat = !want_cool && (err < BAND_LO);
  end

  // relay timing; all requests in one step see the stamps from before it
  time_t el_heat_off, el_cool_off, el_cool_on;
  logic  heat_can_on, cool_can_on, cool_can_off;

  always_comb begin
    el_heat_off  = s1.now_seconds - heat_off_stamp;
    el_cool_off  = s1.now_seconds - cool_off_stamp;
    el_cool_on   = s1.now_seconds - cool_on_stamp;
    heat_can_on  = (el_heat_off > TIME_BITS'(heat_min_off)) &&
                   (el_cool_off > TIME_BITS'(cool_to_heat));
    cool_can_on  = (el_cool_off > TIME_BITS'(cool_min_off)) &&
                   (el_heat_off > TIME_BITS'(heat_to_cool));
    cool_can_off = (cool_state == MODE_ON) && (el_cool_on > TIME_BITS'(cool_min_on));
  end

  always_comb begin
    heat_state_next     = heat_state;
    cool_state_next     = cool_state;
    heat_off_stamp_next = heat_off_stamp;
    cool_on_stamp_next  = cool_on_stamp;
    cool_off_stamp_next = cool_off_stamp;

    if (want_heat) begin
      if (heat_state != MODE_ON) begin
        heat_state_next = heat_can_on ? MODE_ON : MODE_PENDING;
      end
    end else begin
      if (heat_state == MODE_ON) begin
        heat_off_stamp_next = s1.now_seconds;
      end
      heat_state_next = MODE_OFF;
    end

    if (want_cool) begin
      if (cool_state != MODE_ON) begin
        if (cool_can_on) begin
          cool_state_next    = MODE_ON;
          cool_on_stamp_next = s1.now_seconds;
        end else begin
          cool_state_next = MODE_PENDING;
        end
      end
    end else if (cool_can_off) begin
      cool_state_next     = MODE_OFF;
      cool_off_stamp_next = s1.now_seconds;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      heat_state     <= MODE_OFF;
      cool_state     <= MODE_OFF;
      heat_off_stamp <= '0;
      cool_on_stamp  <= '0;
      cool_off_stamp <= '0;
    end else if (advance) begin
      heat_state     <= heat_state_next;
      cool_state     <= cool_state_next;
      heat_off_stamp <= heat_off_stamp_next;
      cool_on_stamp  <= cool_on_stamp_next;
      cool_off_stamp <= cool_off_stamp_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || result.ready) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result.heat_relay <= (heat_state_next == MODE_ON);
      result.cool_relay <= (cool_state_next == MODE_ON);
      result.heat_mode  <= heat_state_next;
      result.cool_mode  <= cool_state_next;
    end
  end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Heat/cool relay controller testbench: drives timed temperature samples and
// timing register writes with random gaps and output stalls, predicts relay
// modes with its own thermostat model and checks every result transaction.
// ----------------------------------------------------------------------------
module tb_top;
  import hcrc_pkg::*;

  localparam int LIMIT    = 400000;
  localparam int TEMP_MAX = 2 ** (TEMP_BITS - 1) - 1;
  localparam int TEMP_MIN = -(2 ** (TEMP_BITS - 1));

  typedef struct {
    logic  heat_relay;
    logic  cool_relay;
    mode_t heat_mode;
    mode_t cool_mode;
  } relay_t;

  logic clk;
  logic rst;

  hcrc_cfg_if cfg_if ();
  hcrc_in_if  in_if ();
  hcrc_out_if out_if ();

  heat_cool_relay_controller u_top (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_if),
    .item   (in_if),
    .result (out_if)
  );

  // thermostat model state
  mode_t heat_st;
  mode_t cool_st;
  time_t heat_on_stamp;
  time_t heat_off_stamp;
  time_t cool_on_stamp;
  time_t cool_off_stamp;
  secs_t cfg_regs [5];

  relay_t expected_relays [$];
  int     mismatches;
  int     cycles = 0;
  int     sink_hold;
  bit     calm;
  int     span;
  time_t  clock_s;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------- model
  function automatic time_t since(time_t now, time_t stamp);
    return now - stamp;
  endfunction

  function automatic int clamp_target(int sp, int beer, int tgt);
    if (sp > beer) begin
      if (sp - beer < int'(WARM_FAR_DIFF) && tgt > beer + int'(WARM_FAR_LIM))
        tgt = beer + int'(WARM_FAR_LIM);
      if (sp - beer < int'(WARM_NEAR_DIFF) && tgt > beer + int'(WARM_NEAR_LIM))
        tgt = beer + int'(WARM_NEAR_LIM);
    end else if (sp - beer < int'(COOL_DIFF) && tgt < beer - int'(COOL_LIM)) begin
      tgt = beer - int'(COOL_LIM);
    end
    return tgt;
  endfunction

  function automatic void request_on(inout mode_t st, inout time_t on_stamp, input time_t now,
                                     input time_t own_off, input secs_t own_min,
                                     input time_t other_off, input secs_t other_gap);
    if (st != MODE_ON) begin
      if (since(now, own_off) > own_min && since(now, other_off) > other_gap) begin
        st       = MODE_ON;
        on_stamp = now;
      end else begin
        st = MODE_PENDING;
      end
    end
  endfunction

  function automatic void heat_off(time_t now);
    if (heat_st == MODE_ON)
      heat_off_stamp = now;
    heat_st = MODE_OFF;
  endfunction

  // a cooler that is pending or still inside its minimum on time is left alone
  function automatic void cool_off(time_t now);
    if (cool_st == MODE_ON && since(now, cool_on_stamp) > cfg_regs[REG_COOL_MIN_ON]) begin
      cool_off_stamp = now;
      cool_st        = MODE_OFF;
    end
  endfunction

  function automatic relay_t predict_relays(item_t it);
    int     err;
    relay_t r;
    err = int'(it.chamber_temp) - clamp_target(int'(it.setpoint_temp), int'(it.beer_temp),
                                               int'(it.loop_target));
    if (err > int'(BAND_HI)) begin
      request_on(cool_st, cool_on_stamp, it.now_seconds, cool_off_stamp,
                 cfg_regs[REG_COOL_MIN_OFF], heat_off_stamp, cfg_regs[REG_HEAT_TO_COOL]);
      heat_off(it.now_seconds);
    end else if (err < int'(BAND_LO)) begin
      request_on(heat_st, heat_on_stamp, it.now_seconds, heat_off_stamp,
                 cfg_regs[REG_HEAT_MIN_OFF], cool_off_stamp, cfg_regs[REG_COOL_TO_HEAT]);
      cool_off(it.now_seconds);
    end else begin
      heat_off(it.now_seconds);
      cool_off(it.now_seconds);
    end
    r.heat_relay = (heat_st == MODE_ON);
    r.cool_relay = (cool_st == MODE_ON);
    r.heat_mode  = heat_st;
    r.cool_mode  = cool_st;
    return r;
  endfunction

  // ---------------------------------------------------------------- stimulus helpers
  function automatic int pick_gap();
    int r;
    if (calm)
      return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic temp_t fit_temp(int v);
    if (v > TEMP_MAX) v = TEMP_MAX;
    if (v < TEMP_MIN) v = TEMP_MIN;
    return temp_t'(v);
  endfunction

  task automatic flag_mismatch(string msg);
    $display("%0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic send_item(item_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid         <= 1'b1;
    in_if.now_seconds   <= it.now_seconds;
    in_if.setpoint_temp <= it.setpoint_temp;
    in_if.beer_temp     <= it.beer_temp;
    in_if.chamber_temp  <= it.chamber_temp;
    in_if.loop_target   <= it.loop_target;
    do @(posedge clk); while (!in_if.ready);
    expected_relays.push_back(predict_relays(it));
  endtask

  task automatic apply_sample(time_t now, int sp, int beer, int ch, int tgt);
    item_t it;
    it.now_seconds   = now;
    it.setpoint_temp = fit_temp(sp);
    it.beer_temp     = fit_temp(beer);
    it.chamber_temp  = fit_temp(ch);
    it.loop_target   = fit_temp(tgt);
    clock_s          = now;
    send_item(it);
  endtask

  task automatic write_reg(cfg_idx_t idx, secs_t val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk); while (!cfg_if.ready);
    if (idx <= REG_COOL_MIN_ON)
      cfg_regs[idx] = val;
    cfg_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  // quiet the input side and let every outstanding result come back
  task automatic drain();
    in_if.valid <= 1'b0;
    while (expected_relays.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // mostly plausible samples near the clamp and deadband edges, time moving forward
  function automatic item_t gen_item();
    item_t it;
    int    beer_v, tg_v, ch_v, diff, jit, sgn;
    if ($urandom_range(0, 99) < 8) begin
      it.now_seconds   = $urandom;
      it.setpoint_temp = temp_t'($urandom);
      it.beer_temp     = temp_t'($urandom);
      it.chamber_temp  = temp_t'($urandom);
      it.loop_target   = temp_t'($urandom);
      clock_s          = it.now_seconds;
      return it;
    end
    case ($urandom_range(0, 49))
      0:         clock_s = 32'hFFFF_FFFF - $urandom_range(0, span);
      1,2,3,4,5,
      6,7,8,9:   clock_s = clock_s + $urandom_range(0, 20);
      10,11,12:  clock_s = clock_s + $urandom_range(0, 4 * span);
      default:   clock_s = clock_s + $urandom_range(0, 2 * span);
    endcase
    if ($urandom_range(0, 3) == 0)
      beer_v = int'($urandom_range(0, 16383)) - 8192;
    else
      beer_v = int'($urandom_range(0, 1600)) - 800;
    jit = int'($urandom_range(0, 6)) - 3;
    case ($urandom_range(0, 5))
      0:       diff = int'($urandom_range(0, 200)) - 100;
      1:       diff = int'(WARM_NEAR_DIFF) + jit;
      2:       diff = int'(WARM_FAR_DIFF) + jit;
      3:       diff = int'(COOL_DIFF) + jit;
      4:       diff = int'($urandom_range(0, 4000)) - 2000;
      default: diff = 0;
    endcase
    jit = int'($urandom_range(0, 6)) - 3;
    case ($urandom_range(0, 4))
      0:       tg_v = beer_v + int'(WARM_FAR_LIM) + jit;
      1:       tg_v = beer_v + int'(WARM_NEAR_LIM) + jit;
      2:       tg_v = beer_v - int'(COOL_LIM) + jit;
      3:       tg_v = beer_v + int'($urandom_range(0, 1200)) - 600;
      default: tg_v = int'($urandom_range(0, 16383)) - 8192;
    endcase
    it.beer_temp     = fit_temp(beer_v);
    it.setpoint_temp = fit_temp(beer_v + diff);
    it.loop_target   = fit_temp(tg_v);
    tg_v = clamp_target(int'(it.setpoint_temp), int'(it.beer_temp), int'(it.loop_target));
    sgn  = ($urandom_range(0, 1) == 0) ? -1 : 1;
    case ($urandom_range(0, 7))
      0,1:     ch_v = tg_v + sgn * int'($urandom_range(8, 9));
      6,7:     ch_v = tg_v + int'($urandom_range(0, 800)) - 400;
      default: ch_v = tg_v + int'($urandom_range(0, 60)) - 30;
    endcase
    it.chamber_temp = fit_temp(ch_v);
    it.now_seconds  = clock_s;
    return it;
  endfunction

  task automatic run_random(int count);
    repeat (count) send_item(gen_item());
  endtask

  // ---------------------------------------------------------------- tests
  task automatic test_field_extremes();
    apply_sample(32'd0, TEMP_MIN, TEMP_MAX, TEMP_MIN, TEMP_MAX);
    apply_sample(32'd1, TEMP_MAX, TEMP_MIN, TEMP_MAX, TEMP_MIN);
    apply_sample(32'd2, 0, 0, 0, 0);
    apply_sample(32'd3, -1, -1, TEMP_MAX, TEMP_MAX);
  endtask

  // heat/cool changeovers, cooler minimum on time and pending holds, with exact edges
  task automatic test_short_cycle();
    apply_sample(32'd400, 0, 0, -100, 0);
    apply_sample(32'd410, 0, 0, 100, 0);
    apply_sample(32'd420, 0, 0, -100, 0);
    apply_sample(32'd530, 0, 0, 0, 0);
    apply_sample(32'd531, 0, 0, 0, 0);
    apply_sample(32'd540, 0, 0, 100, 0);
    apply_sample(32'd550, 0, 0, 0, 0);
    apply_sample(32'd560, 0, 0, -100, 0);
    apply_sample(32'd831, 0, 0, -100, 0);
    apply_sample(32'd832, 0, 0, -100, 0);
    apply_sample(32'd833, 0, 0, 100, 0);
  endtask

  task automatic test_target_clamp();
    apply_sample(32'd2000, 79, 0, 152, 200);
    apply_sample(32'd3000, 79, 0, 151, 200);
    apply_sample(32'd4000, 80, 0, 191, 200);
    apply_sample(32'd5000, 31, 0, 89, 200);
    apply_sample(32'd6000, 32, 0, 108, 100);
    apply_sample(32'd7000, -81, 0, -311, -400);
    apply_sample(32'd8000, -80, 0, -409, -400);
  endtask

  task automatic test_time_wrap();
    apply_sample(32'hFFFF_FFF0, 0, 0, -100, 0);
    apply_sample(32'h0000_0100, 0, 0, 100, 0);
    apply_sample(32'h0000_0400, 0, 0, 0, 0);
  endtask

  task automatic test_config_extremes();
    drain();
    for (int i = REG_HEAT_MIN_OFF; i <= REG_COOL_MIN_ON; i++)
      write_reg(cfg_idx_t'(i), '0);
    span = 20;
    run_random(40);
    drain();
    for (int i = REG_HEAT_MIN_OFF; i <= REG_COOL_MIN_ON; i++)
      write_reg(cfg_idx_t'(i), '1);
    // indexes past the last register must not disturb anything
    for (int i = REG_COOL_MIN_ON + 1; i < 2 ** IDX_BITS; i++)
      write_reg(cfg_idx_t'(i), secs_t'($urandom));
    span = 70000;
    run_random(40);
  endtask

  task automatic test_random_phases();
    int    r;
    secs_t v;
    for (int p = 0; p < 6; p++) begin
      drain();
      span = 20;
      for (int i = REG_HEAT_MIN_OFF; i <= REG_COOL_MIN_ON; i++) begin
        r = $urandom_range(0, 9);
        if (r == 0)      v = '0;
        else if (r == 1) v = '1;
        else             v = secs_t'($urandom_range(0, 600));
        write_reg(cfg_idx_t'(i), v);
        if (int'(v) + 20 > span) span = int'(v) + 20;
      end
      calm = ($urandom_range(0, 3) == 0);
      run_random(125);
    end
    calm = 1'b0;
  endtask

  // ---------------------------------------------------------------- sequence
  initial begin
    rst                 <= 1'b1;
    in_if.valid         <= 1'b0;
    in_if.now_seconds   <= '0;
    in_if.setpoint_temp <= '0;
    in_if.beer_temp     <= '0;
    in_if.chamber_temp  <= '0;
    in_if.loop_target   <= '0;
    cfg_if.valid        <= 1'b0;
    cfg_if.index        <= REG_HEAT_MIN_OFF;
    cfg_if.data         <= '0;
    mismatches = 0;
    calm       = 1'b0;
    span       = 600;
    clock_s    = '0;
    heat_st        = MODE_OFF;
    cool_st        = MODE_OFF;
    heat_on_stamp  = '0;
    heat_off_stamp = '0;
    cool_on_stamp  = '0;
    cool_off_stamp = '0;
    cfg_regs[REG_HEAT_MIN_OFF] = HEAT_MIN_OFF_RST;
    cfg_regs[REG_COOL_TO_HEAT] = COOL_TO_HEAT_RST;
    cfg_regs[REG_COOL_MIN_OFF] = COOL_MIN_OFF_RST;
    cfg_regs[REG_HEAT_TO_COOL] = HEAT_TO_COOL_RST;
    cfg_regs[REG_COOL_MIN_ON]  = COOL_MIN_ON_RST;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_field_extremes();
    test_short_cycle();
    test_target_clamp();
    test_time_wrap();
    test_config_extremes();
    test_random_phases();

    drain();
    repeat (6) @(posedge clk);
    if (mismatches == 0)
      $display("[heat_cool_relay_controller] OK");
    else
      $display("[heat_cool_relay_controller] ERROR");
    $finish;
  end

  // result side: random backpressure
  always @(posedge clk) begin
    if (rst) begin
      out_if.ready <= 1'b0;
      sink_hold    <= 0;
    end else if (sink_hold > 0) begin
      out_if.ready <= 1'b0;
      sink_hold    <= sink_hold - 1;
    end else begin
      out_if.ready <= 1'b1;
      sink_hold    <= pick_gap();
    end
  end

  // compare each result transaction with the oldest prediction
  always @(posedge clk) begin
    relay_t want;
    if (!rst && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (expected_relays.size() == 0) begin
        flag_mismatch("result transaction with no sample outstanding");
      end else begin
        want = expected_relays.pop_front();
        if (out_if.heat_relay !== want.heat_relay)
          flag_mismatch($sformatf("heat_relay got %b want %b", out_if.heat_relay,
                                  want.heat_relay));
        if (out_if.cool_relay !== want.cool_relay)
          flag_mismatch($sformatf("cool_relay got %b want %b", out_if.cool_relay,
                                  want.cool_relay));
        if (out_if.heat_mode !== want.heat_mode)
          flag_mismatch($sformatf("heat_mode got %0d want %0d", out_if.heat_mode,
                                  want.heat_mode));
        if (out_if.cool_mode !== want.cool_mode)
          flag_mismatch($sformatf("cool_mode got %0d want %0d", out_if.cool_mode,
                                  want.cool_mode));
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("[heat_cool_relay_controller] ERROR");
      $finish;
    end
  end

endmodule

[heat_cool_relay_controller.f]
sv/hcrc_pkg.sv
sv/hcrc_if.sv
sv/heat_cool_relay_controller.sv
tb/tb_top.sv
